>>> hw/rtl/womf_pkg.sv
// Package with the shared constants, types and tap table of the wrap-around median filter.
`timescale 1ns / 1ps

package womf_pkg;

  // Default frame store dimensions.
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  // Field and register widths.
  localparam int COORD_W    = 9;
  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 10;
  localparam int MODE_W     = 2;
  localparam int THR_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Window geometry: nine taps, the centre always fetched as tap four.
  localparam int TAPS       = 9;
  localparam int TAP_W      = 4;
  localparam int CENTER_TAP = 4;
  localparam int LAST_TAP   = TAPS - 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH,
    CFG_HEIGHT,
    CFG_MODE,
    CFG_THRESHOLD
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_OUTLIER,
    MODE_SQUARE,
    MODE_CROSS,
    MODE_PASS
  } filter_mode_t;

  typedef enum logic {
    OP_WRITE,
    OP_READ
  } opcode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_LAST,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic signed [2:0] dr;
    logic signed [2:0] dc;
  } tap_offset_t;

  // Row and column offset of each tap, for the square or the cross window.
  function automatic tap_offset_t tap_offset(input logic is_cross, input logic [TAP_W-1:0] k);
    tap_offset_t o;
    o.dr = 3'sd0;
    o.dc = 3'sd0;
    if (is_cross) begin
      case (k)
        4'd0: begin o.dr = 3'sd0;  o.dc = -3'sd2; end
        4'd1: begin o.dr = 3'sd0;  o.dc = -3'sd1; end
        4'd2: begin o.dr = 3'sd0;  o.dc = 3'sd1;  end
        4'd3: begin o.dr = 3'sd0;  o.dc = 3'sd2;  end
        4'd4: begin o.dr = 3'sd0;  o.dc = 3'sd0;  end
        4'd5: begin o.dr = -3'sd2; o.dc = 3'sd0;  end
        4'd6: begin o.dr = -3'sd1; o.dc = 3'sd0;  end
        4'd7: begin o.dr = 3'sd1;  o.dc = 3'sd0;  end
        4'd8: begin o.dr = 3'sd2;  o.dc = 3'sd0;  end
        default: begin o.dr = 3'sd0; o.dc = 3'sd0; end
      endcase
    end else begin
      case (k)
        4'd0: begin o.dr = -3'sd1; o.dc = -3'sd1; end
        4'd1: begin o.dr = -3'sd1; o.dc = 3'sd0;  end
        4'd2: begin o.dr = -3'sd1; o.dc = 3'sd1;  end
        4'd3: begin o.dr = 3'sd0;  o.dc = -3'sd1; end
        4'd4: begin o.dr = 3'sd0;  o.dc = 3'sd0;  end
        4'd5: begin o.dr = 3'sd0;  o.dc = 3'sd1;  end
        4'd6: begin o.dr = 3'sd1;  o.dc = -3'sd1; end
        4'd7: begin o.dr = 3'sd1;  o.dc = 3'sd0;  end
        4'd8: begin o.dr = 3'sd1;  o.dc = 3'sd1;  end
        default: begin o.dr = 3'sd0; o.dc = 3'sd0; end
      endcase
    end
    return o;
  endfunction

endpackage

>>> hw/rtl/womf_in_if.sv
// Request channel interface: pixel writes and filtered-pixel reads.
`timescale 1ns / 1ps

interface womf_in_if;
  import womf_pkg::*;

  logic               valid;
  logic               ready;
  logic               opcode;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [PIX_W-1:0]   red;
  logic [PIX_W-1:0]   green;
  logic [PIX_W-1:0]   blue;

  modport source (output valid, output opcode, output row, output col,
                  output red, output green, output blue, input ready);
  modport sink   (input valid, input opcode, input row, input col,
                  input red, input green, input blue, output ready);
endinterface

>>> hw/rtl/womf_out_if.sv
// Result channel interface: one filtered gray pixel per transaction.
`timescale 1ns / 1ps

interface womf_out_if;
  import womf_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] filtered_pixel;

  modport source (output valid, output filtered_pixel, input ready);
  modport sink   (input valid, input filtered_pixel, output ready);
endinterface

>>> hw/rtl/wraparound_outlier_median_filter_unit.sv
// Top level of the wrap-around outlier and median filter over a gray frame store.
//
//   Channel   Direction  Transaction
//   pix_in    sink       opcode, row, col, red, green, blue (write pixel or read request)
//   pix_out   source     filtered_pixel (one per read request)
//   cfg_*     sink       cfg_we, cfg_index, cfg_data (register write, no read-back)
//
// A write inside the frame is stored in the same cycle it is accepted; it gives no result.
// A read fetches nine pixels from the single-port frame memory, one per cycle, and
// sorts them by insertion as they arrive; the result then passes through the last and
// done states into the output register, and the next request is accepted after that.
// A read outside the frame skips the fetch and gives 0. Reset (rst, synchronous) clears
// the sequencer, the configuration registers and out_valid; the frame memory is not cleared.
// A result waits in the output register while pix_out is stalled; a new request is
// accepted meanwhile, and that one holds in its final state until the register frees.
`timescale 1ns / 1ps

module wraparound_outlier_median_filter_unit #(
  parameter int MAX_WIDTH  = womf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = womf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [womf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [womf_pkg::CFG_DATA_W-1:0] cfg_data,
  womf_in_if.sink                         pix_in,
  womf_out_if.source                      pix_out
);
  import womf_pkg::*;

  // Sizes beyond what the size registers can express are never used.
  localparam int EFF_W = (MAX_WIDTH < 1023) ? MAX_WIDTH : 1023;
  localparam int EFF_H = (MAX_HEIGHT < 1023) ? MAX_HEIGHT : 1023;
  localparam int CW    = $clog2(EFF_W);
  localparam int RW    = $clog2(EFF_H);
  localparam int AW    = RW + CW;
  localparam int DEPTH = EFF_H * (2 ** CW);
  localparam logic [SIZE_W-1:0] W_LIMIT = SIZE_W'(EFF_W);
  localparam logic [SIZE_W-1:0] H_LIMIT = SIZE_W'(EFF_H);
  localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(2);

  // Wrap a coordinate plus a small offset into the range [0, n).
  function automatic logic [SIZE_W-1:0] wrap_coord(input logic [SIZE_W-1:0] c,
                                                   input logic signed [2:0] d,
                                                   input logic [SIZE_W-1:0] n);
    logic signed [SIZE_W+1:0] t;
    logic signed [SIZE_W+1:0] ns;
    ns = $signed({2'b00, n});
    t  = $signed({2'b00, c}) + $signed({{(SIZE_W-1){d[2]}}, d});
    if (t < 0) begin
      t = t + ns;
    end else if (t >= ns) begin
      t = t - ns;
    end
    return t[SIZE_W-1:0];
  endfunction

  // Configuration registers.
  logic [SIZE_W-1:0]       image_width;
  logic [SIZE_W-1:0]       image_height;
  filter_mode_t            filter_mode;
  logic signed [THR_W-1:0] outlier_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= SIZE_W'(512);
      image_height      <= SIZE_W'(512);
      filter_mode       <= MODE_OUTLIER;
      outlier_threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_WIDTH:     image_width       <= cfg_data[SIZE_W-1:0];
        CFG_HEIGHT:    image_height      <= cfg_data[SIZE_W-1:0];
        CFG_MODE:      filter_mode       <= filter_mode_t'(cfg_data[MODE_W-1:0]);
        CFG_THRESHOLD: outlier_threshold <= $signed(cfg_data[THR_W-1:0]);
        default: ;
      endcase
    end
  end

  // Effective frame size, clamped to what the store holds.
  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;

  always_comb begin
    if (image_width < MIN_SIZE) w_eff = MIN_SIZE;
    else if (image_width > W_LIMIT) w_eff = W_LIMIT;
    else w_eff = image_width;
    if (image_height < MIN_SIZE) h_eff = MIN_SIZE;
    else if (image_height > H_LIMIT) h_eff = H_LIMIT;
    else h_eff = image_height;
  end

  // Request decode.
  seq_state_t        state;
  seq_state_t        state_next;
  logic              in_acc;
  logic              in_bounds;
  logic              is_read;
  logic [SIZE_W-1:0] in_row;
  logic [SIZE_W-1:0] in_col;

  assign in_acc    = pix_in.valid && pix_in.ready;
  assign is_read   = (opcode_t'(pix_in.opcode) == OP_READ);
  assign in_row    = {1'b0, pix_in.row};
  assign in_col    = {1'b0, pix_in.col};
  assign in_bounds = (in_row < h_eff) && (in_col < w_eff);

  // Gray conversion: divide the channel sum by three with a reciprocal multiply.
  logic [SIZE_W-1:0] rgb_sum;
  logic [19:0]       gray_prod;
  logic [PIX_W-1:0]  gray;

  assign rgb_sum   = SIZE_W'(pix_in.red) + SIZE_W'(pix_in.green) + SIZE_W'(pix_in.blue);
  assign gray_prod = 20'(rgb_sum) * 20'd683;
  assign gray      = gray_prod[18:11];

  // Read sequencing state.
  logic [TAP_W-1:0]  cnt;
  logic [SIZE_W-1:0] cur_row;
  logic [SIZE_W-1:0] cur_col;
  logic              zero_res;
  logic              rd_en;
  logic              load_out;
  logic              out_valid;
  logic [PIX_W-1:0]  out_pixel;

  // Neighbour address for the current tap.
  tap_offset_t       off;
  logic [SIZE_W-1:0] tap_row;
  logic [SIZE_W-1:0] tap_col;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     mem_addr;
  logic              mem_we;

  assign off      = tap_offset(filter_mode == MODE_CROSS, cnt);
  assign tap_row  = wrap_coord(cur_row, off.dr, h_eff);
  assign tap_col  = wrap_coord(cur_col, off.dc, w_eff);
  assign rd_addr  = {tap_row[RW-1:0], tap_col[CW-1:0]};
  assign wr_addr  = {in_row[RW-1:0], in_col[CW-1:0]};
  assign mem_we   = in_acc && !is_read && in_bounds;
  assign mem_addr = rd_en ? rd_addr : wr_addr;

  // Single-port frame memory: writes only while idle, reads only while fetching.
  logic [PIX_W-1:0] frame [DEPTH];
  logic [PIX_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame[mem_addr] <= gray;
    end
    if (rd_en) begin
      rd_data <= frame[mem_addr];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && is_read) begin
          state_next = in_bounds ? S_FETCH : S_DONE;
        end
      end
      S_FETCH: begin
        if (cnt == TAP_W'(LAST_TAP)) state_next = S_LAST;
      end
      S_LAST: state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || pix_out.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    pix_in.ready = 1'b0;
    rd_en        = 1'b0;
    load_out     = 1'b0;
    case (state)
      S_IDLE:  pix_in.ready = 1'b1;
      S_FETCH: rd_en = 1'b1;
      S_LAST:  ;
      S_DONE:  load_out = !out_valid || pix_out.ready;
      default: ;
    endcase
  end

  // Control registers of the sequencer and the tap pipeline.
  logic             tap_valid;
  logic [TAP_W-1:0] tap_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap_valid <= 1'b0;
    end else begin
      state     <= state_next;
      tap_valid <= rd_en;
    end
  end

  // Request capture and tap counter.
  always_ff @(posedge clk) begin
    tap_idx <= cnt;
    if (in_acc) begin
      cur_row  <= in_row;
      cur_col  <= in_col;
      zero_res <= !in_bounds;
      cnt      <= '0;
    end else if (rd_en) begin
      cnt <= cnt + TAP_W'(1);
    end
  end

  // Insertion of the arriving pixel into the sorted window.
  logic [PIX_W-1:0] sorted      [TAPS];
  logic [PIX_W-1:0] sorted_next [TAPS];

  always_comb begin
    if (sorted[0] <= rd_data) begin
      sorted_next[0] = sorted[0];
    end else begin
      sorted_next[0] = rd_data;
    end
    for (int i = 1; i < TAPS; i++) begin
      if (sorted[i] <= rd_data) begin
        sorted_next[i] = sorted[i];
      end else if (sorted[i-1] <= rd_data) begin
        sorted_next[i] = rd_data;
      end else begin
        sorted_next[i] = sorted[i-1];
      end
    end
  end

  // Accumulation of the centre, the neighbour sum and the sorted window.
  logic [PIX_W+2:0] nb_sum;
  logic [PIX_W-1:0] center;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      nb_sum <= '0;
      for (int i = 0; i < TAPS; i++) begin
        sorted[i] <= '1;
      end
    end else if (tap_valid) begin
      if (tap_idx == TAP_W'(CENTER_TAP)) begin
        center <= rd_data;
      end else begin
        nb_sum <= nb_sum + (PIX_W+3)'(rd_data);
      end
      sorted <= sorted_next;
    end
  end

  // Result selection.
  logic [PIX_W-1:0]        mean;
  logic signed [PIX_W+1:0] diff;
  logic signed [PIX_W+1:0] thr_ext;
  logic [PIX_W-1:0]        result;

  assign mean    = nb_sum[PIX_W+2:3];
  assign diff    = $signed({2'b00, center}) - $signed({2'b00, mean});
  assign thr_ext = (PIX_W+2)'(outlier_threshold);

  always_comb begin
    case (filter_mode)
      MODE_OUTLIER:         result = (diff > thr_ext) ? mean : center;
      MODE_SQUARE, MODE_CROSS: result = sorted[CENTER_TAP];
      default:              result = center;
    endcase
    if (zero_res) result = '0;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pixel <= result;
    end
  end

  assign pix_out.valid          = out_valid;
  assign pix_out.filtered_pixel = out_pixel;

endmodule

>>> test/womf_filter_checker.sv
// Checker that predicts and compares every filtered-pixel transaction of the filter unit.
`timescale 1ns / 1ps

module womf_filter_checker #(
  parameter int MAX_WIDTH  = womf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = womf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [womf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [womf_pkg::CFG_DATA_W-1:0] cfg_data,
  womf_in_if                              pix_in,
  womf_out_if                             pix_out,
  output int                              mismatches,
  output int                              outstanding
);
  import womf_pkg::*;

  // One read still waiting for its result, with the pixel it should return.
  typedef struct {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   pixel;
  } pending_read_t;

  pending_read_t pending_reads[$];
  pending_read_t oldest_read;

  // Our own copy of the frame store and of the registers.
  logic [PIX_W-1:0]        gray_store [0:MAX_WIDTH*MAX_HEIGHT-1];
  logic [SIZE_W-1:0]       width_reg;
  logic [SIZE_W-1:0]       height_reg;
  filter_mode_t            mode_reg;
  logic signed [THR_W-1:0] threshold_reg;

  // Size registers outside the legal range are pinned to it.
  function automatic int clamp_dim(input int v, input int lim);
    if (v < 2) return 2;
    if (v > lim) return lim;
    return v;
  endfunction

  // Stored pixel at an offset from (r, c), wrapped around the frame edges.
  function automatic int wrapped_pixel(input int r, input int c, input int dr, input int dc,
                                       input int h, input int w);
    return int'(gray_store[((r + h + dr) % h) * MAX_WIDTH + ((c + w + dc) % w)]);
  endfunction

  function automatic int median_of_nine(input int v [9]);
    int t;
    int j;
    for (int i = 1; i < 9; i++) begin
      t = v[i];
      j = i - 1;
      while (j >= 0 && v[j] > t) begin
        v[j + 1] = v[j];
        j--;
      end
      v[j + 1] = t;
    end
    return v[4];
  endfunction

  // Filtered value the block should return for a read at (r, c).
  function automatic logic [PIX_W-1:0] predict_filtered_pixel(input int r, input int c);
    int w;
    int h;
    int centre;
    int sum;
    int mean;
    int k;
    int window [9];
    w = clamp_dim(int'(width_reg), MAX_WIDTH);
    h = clamp_dim(int'(height_reg), MAX_HEIGHT);
    if (r >= h || c >= w) return '0;
    centre = wrapped_pixel(r, c, 0, 0, h, w);
    case (mode_reg)
      MODE_OUTLIER: begin
        sum = 0;
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++)
            if (dr != 0 || dc != 0) sum += wrapped_pixel(r, c, dr, dc, h, w);
        mean = sum / 8;
        if (centre - mean > int'(threshold_reg)) return PIX_W'(mean);
        return PIX_W'(centre);
      end
      MODE_SQUARE: begin
        k = 0;
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++) begin
            window[k] = wrapped_pixel(r, c, dr, dc, h, w);
            k++;
          end
        return PIX_W'(median_of_nine(window));
      end
      MODE_CROSS: begin
        window = '{wrapped_pixel(r, c, 0, -2, h, w), wrapped_pixel(r, c, 0, -1, h, w),
                   wrapped_pixel(r, c, 0, 1, h, w), wrapped_pixel(r, c, 0, 2, h, w),
                   centre,
                   wrapped_pixel(r, c, -2, 0, h, w), wrapped_pixel(r, c, -1, 0, h, w),
                   wrapped_pixel(r, c, 1, 0, h, w), wrapped_pixel(r, c, 2, 0, h, w)};
        return PIX_W'(median_of_nine(window));
      end
      default: return PIX_W'(centre);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int r, input int c,
                                 input int got, input int want);
    $display("%0t: %s at row %0d col %0d: got %0d, expected %0d", $time, what, r, c, got,
             want);
    mismatches++;
  endtask

  // Results are checked before new requests are recorded, so that a result can never
  // be matched against a read accepted at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      pending_reads.delete();
      width_reg     = SIZE_W'(DEF_MAX_WIDTH);
      height_reg    = SIZE_W'(DEF_MAX_HEIGHT);
      mode_reg      = MODE_OUTLIER;
      threshold_reg = '0;
      outstanding   = 0;
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        if (pending_reads.size() == 0) begin
          report_mismatch("result transaction with no read pending", -1, -1,
                          int'(pix_out.filtered_pixel), -1);
        end else begin
          oldest_read = pending_reads.pop_front();
          if (pix_out.filtered_pixel !== oldest_read.pixel)
            report_mismatch("filtered_pixel wrong", int'(oldest_read.row),
                            int'(oldest_read.col), int'(pix_out.filtered_pixel),
                            int'(oldest_read.pixel));
        end
      end

      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_WIDTH:     width_reg = cfg_data[SIZE_W-1:0];
          CFG_HEIGHT:    height_reg = cfg_data[SIZE_W-1:0];
          CFG_MODE:      mode_reg = filter_mode_t'(cfg_data[MODE_W-1:0]);
          CFG_THRESHOLD: threshold_reg = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end

      // Writes land in the frame store only when inside the configured size.
      if (pix_in.valid && pix_in.ready) begin
        if (opcode_t'(pix_in.opcode) == OP_WRITE) begin
          if (int'(pix_in.row) < clamp_dim(int'(height_reg), MAX_HEIGHT) &&
              int'(pix_in.col) < clamp_dim(int'(width_reg), MAX_WIDTH))
            gray_store[int'(pix_in.row) * MAX_WIDTH + int'(pix_in.col)] =
              PIX_W'((int'(pix_in.red) + int'(pix_in.green) + int'(pix_in.blue)) / 3);
        end else begin
          pending_reads.push_back('{row: pix_in.row, col: pix_in.col,
                                    pixel: predict_filtered_pixel(int'(pix_in.row),
                                                                  int'(pix_in.col))});
        end
      end
      outstanding = pending_reads.size();
    end
  end

endmodule

>>> test/tb_wraparound_outlier_median_filter_unit.sv
// Testbench top: stimulus, back-pressure and verdict for the wrap-around filter unit.
`timescale 1ns / 1ps

module tb_wraparound_outlier_median_filter_unit;
  import womf_pkg::*;

  localparam int FRAME_W      = DEF_MAX_WIDTH;
  localparam int FRAME_H      = DEF_MAX_HEIGHT;
  localparam int ITEM_TARGET  = 1250;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_LIMIT   = 5000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    outstanding;

  womf_in_if  pix_in_bus ();
  womf_out_if pix_out_bus ();

  // Stimulus bookkeeping: which stored pixels hold a defined value.
  bit pixel_written [0:FRAME_W*FRAME_H-1];
  int eff_w;
  int eff_h;
  int items_sent;
  bit gaps_on;
  bit hold_results;
  int idle_cycles;

  wraparound_outlier_median_filter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pix_in   (pix_in_bus),
    .pix_out  (pix_out_bus)
  );

  womf_filter_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_in     (pix_in_bus),
    .pix_out    (pix_out_bus),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_dim(input int v, input int lim);
    if (v < 2) return 2;
    if (v > lim) return lim;
    return v;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Coordinates lean towards the frame edges, where the wrap-around happens.
  function automatic int pick_coord(input int lim);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return lim - 1;
      default: return $urandom_range(0, lim - 1);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return CFG_DATA_W'($urandom_range(0, 1));
      1:       return CFG_DATA_W'(512);
      2:       return CFG_DATA_W'($urandom_range(513, 1023));
      3:       return CFG_DATA_W'($urandom_range(13, 511));
      default: return CFG_DATA_W'($urandom_range(2, 12));
    endcase
  endfunction

  // Threshold in the low nine bits; the unused top bit is random.
  function automatic logic [CFG_DATA_W-1:0] pick_threshold();
    logic [THR_W-1:0] t;
    case ($urandom_range(0, 7))
      0:       t = 9'h100;
      1:       t = 9'h101;
      2:       t = 9'h0ff;
      3:       t = 9'h000;
      default: t = THR_W'($urandom_range(0, 511));
    endcase
    return {1'($urandom_range(0, 1)), t};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_mode();
    return {8'($urandom_range(0, 255)), 2'($urandom_range(0, 3))};
  endfunction

  task automatic pick_colour(output logic [PIX_W-1:0] red, green, blue);
    case ($urandom_range(0, 9))
      0: begin
        red = 8'd0; green = 8'd0; blue = 8'd0;
      end
      1: begin
        red = 8'd255; green = 8'd255; blue = 8'd255;
      end
      default: begin
        red = 8'($urandom_range(0, 255));
        green = 8'($urandom_range(0, 255));
        blue = 8'($urandom_range(0, 255));
      end
    endcase
  endtask

  // Offer one transaction and return at the edge where it is accepted.
  task automatic send_item(input opcode_t op, input int r, input int c,
                           input logic [PIX_W-1:0] red, green, blue);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      pix_in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_in_bus.opcode = op;
    pix_in_bus.row    = COORD_W'(r);
    pix_in_bus.col    = COORD_W'(c);
    pix_in_bus.red    = red;
    pix_in_bus.green  = green;
    pix_in_bus.blue   = blue;
    pix_in_bus.valid  = 1'b1;
    @(posedge clk);
    while (!pix_in_bus.ready) @(posedge clk);
  endtask

  task automatic write_pixel(input int r, input int c, input logic [PIX_W-1:0] red, green,
                             blue);
    send_item(OP_WRITE, r, c, red, green, blue);
    if (r < eff_h && c < eff_w) begin
      pixel_written[r * FRAME_W + c] = 1'b1;
      items_sent++;
    end
  endtask

  // Every pixel of the square and the cross around (r, c) gets a value before a read.
  task automatic fill_window(input int r, input int c);
    int rr;
    int cc;
    logic [PIX_W-1:0] red, green, blue;
    for (int dr = -2; dr <= 2; dr++)
      for (int dc = -2; dc <= 2; dc++)
        if ((dr < 0 ? -dr : dr) + (dc < 0 ? -dc : dc) <= 2) begin
          rr = (r + eff_h + dr) % eff_h;
          cc = (c + eff_w + dc) % eff_w;
          if (!pixel_written[rr * FRAME_W + cc]) begin
            pick_colour(red, green, blue);
            write_pixel(rr, cc, red, green, blue);
          end
        end
  endtask

  task automatic read_pixel(input int r, input int c);
    logic [PIX_W-1:0] red, green, blue;
    if (r < eff_h && c < eff_w) fill_window(r, c);
    pick_colour(red, green, blue);
    send_item(OP_READ, r, c, red, green, blue);
    items_sent++;
  endtask

  // Hold the request channel idle until every result has come, then let the block settle.
  task automatic wait_drained();
    @(negedge clk);
    pix_in_bus.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] w, h, mode, thr);
    wait_drained();
    cfg_index = CFG_WIDTH;
    cfg_data  = w;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_index = CFG_HEIGHT;
    cfg_data  = h;
    @(negedge clk);
    cfg_index = CFG_MODE;
    cfg_data  = mode;
    @(negedge clk);
    cfg_index = CFG_THRESHOLD;
    cfg_data  = thr;
    @(negedge clk);
    cfg_we = 1'b0;
    eff_w = clamp_dim(int'(w), FRAME_W);
    eff_h = clamp_dim(int'(h), FRAME_H);
  endtask

  // A coordinate pair with at least one part outside the frame, if the frame allows it.
  task automatic pick_outside(output int r, output int c);
    if (eff_h < FRAME_H && (eff_w == FRAME_W || $urandom_range(0, 1) == 1)) begin
      r = $urandom_range(eff_h, FRAME_H - 1);
      c = $urandom_range(0, FRAME_W - 1);
    end else if (eff_w < FRAME_W) begin
      r = $urandom_range(0, FRAME_H - 1);
      c = $urandom_range(eff_w, FRAME_W - 1);
    end else begin
      r = pick_coord(eff_h);
      c = pick_coord(eff_w);
    end
  endtask

  task automatic random_action();
    int r;
    int c;
    logic [PIX_W-1:0] red, green, blue;
    r = pick_coord(eff_h);
    c = pick_coord(eff_w);
    pick_colour(red, green, blue);
    case ($urandom_range(0, 19))
      10, 11, 12: write_pixel(r, c, red, green, blue);
      13: begin
        pick_outside(r, c);
        write_pixel(r, c, red, green, blue);
      end
      14, 15: begin
        pick_outside(r, c);
        read_pixel(r, c);
      end
      // A lone bright or dark pixel in a defined neighbourhood, read back at once.
      16, 17: begin
        fill_window(r, c);
        if ($urandom_range(0, 1) == 1) write_pixel(r, c, 8'd255, 8'd255, 8'd255);
        else write_pixel(r, c, 8'd0, 8'd0, 8'd0);
        read_pixel(r, c);
      end
      18: wait_drained();
      default: read_pixel(r, c);
    endcase
  endtask

  // Result side: random stalls, long ready stretches, and one long hold-off on request.
  initial begin
    int stall;
    wait (rst === 1'b0);
    forever begin
      if (hold_results) begin
        pix_out_bus.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_results = 1'b0;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          pix_out_bus.ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
        pix_out_bus.ready = 1'b1;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 100)) @(negedge clk);
        else repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  // Watchdog on cycles in which no transaction of any kind takes place.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((pix_in_bus.valid && pix_in_bus.ready) || (pix_out_bus.valid && pix_out_bus.ready) ||
          cfg_we || rst)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Main stimulus: directed checks on a 2x2 frame, then random phases.
  initial begin
    int phase;
    int actions;
    logic [CFG_DATA_W-1:0] w_data;
    logic [CFG_DATA_W-1:0] h_data;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = CFG_WIDTH;
    cfg_data          = '0;
    pix_in_bus.valid  = 1'b0;
    pix_in_bus.opcode = OP_WRITE;
    pix_in_bus.row    = '0;
    pix_in_bus.col    = '0;
    pix_in_bus.red    = '0;
    pix_in_bus.green  = '0;
    pix_in_bus.blue   = '0;
    pix_out_bus.ready = 1'b0;
    hold_results      = 1'b0;
    gaps_on           = 1'b0;
    items_sent        = 0;
    eff_w             = FRAME_W;
    eff_h             = FRAME_H;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // Size registers below the minimum fold to a 2x2 frame, which wraps onto itself.
    configure(10'd1, 10'd0, {8'd0, MODE_SQUARE}, 10'd0);
    write_pixel(0, 0, 8'd255, 8'd255, 8'd255);
    write_pixel(0, 1, 8'd255, 8'd255, 8'd254);
    write_pixel(1, 0, 8'd255, 8'd0, 8'd0);
    write_pixel(1, 1, 8'd1, 8'd2, 8'd3);
    write_pixel(511, 511, 8'd0, 8'd255, 8'd0);
    read_pixel(0, 0);
    read_pixel(1, 1);
    read_pixel(511, 0);
    read_pixel(0, 511);
    configure(10'd2, 10'd2, {8'd0, MODE_CROSS}, 10'd0);
    read_pixel(1, 0);
    // The unused mode hands back the stored centre pixel.
    configure(10'd2, 10'd2, {8'd0, MODE_PASS}, 10'd0);
    read_pixel(0, 1);
    // Lowest threshold always replaces, the highest never does.
    configure(10'd2, 10'd2, {8'd0, MODE_OUTLIER}, 10'h100);
    read_pixel(0, 0);
    configure(10'd2, 10'd2, {8'd0, MODE_OUTLIER}, 10'h0ff);
    read_pixel(1, 0);

    // Random phases; the first three pin the size extremes.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      phase++;
      case (phase)
        1: begin
          w_data = 10'd1023;
          h_data = 10'd2;
        end
        2: begin
          w_data = 10'd0;
          h_data = 10'd512;
        end
        3: begin
          w_data = 10'd512;
          h_data = 10'd512;
        end
        default: begin
          w_data = pick_size();
          h_data = pick_size();
        end
      endcase
      configure(w_data, h_data, pick_mode(), pick_threshold());
      gaps_on = ($urandom_range(0, 3) != 0);
      if (phase == 3) hold_results = 1'b1;
      // A phase stops early once enough transactions have been sent.
      actions = $urandom_range(20, 80);
      while (actions > 0 && items_sent < ITEM_TARGET) begin
        random_action();
        actions--;
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
